/* src/pab_pkg.sv */
// Package for the pixel alpha blender: formats, register indexes, stage control words.
package pab_pkg;

  // Pixel layouts as coded in the format registers.
  typedef enum logic [1:0] {
    FMT_RGB  = 2'd0,
    FMT_BGR  = 2'd1,
    FMT_RGBA = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_GLOBAL_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd1;
  localparam logic [1:0] CFG_TARGET_FORMAT = 2'd2;

  localparam logic [7:0] ALPHA_RESET = 8'hFF;
  localparam logic [7:0] ALPHA_FULL  = 8'hFF;
  localparam int unsigned LANES      = 4;

  // Source of the top byte of the result.
  typedef enum logic [1:0] {
    B3_TARGET = 2'd0,
    B3_OPAQUE = 2'd1,
    B3_BLEND  = 2'd2
  } b3_sel_t;

  // Control word that travels with a pixel after the alpha has been settled.
  typedef struct packed {
    logic    skip;
    logic    copy;
    logic    trunc;
    b3_sel_t b3_sel;
  } blend_ctl_t;

  // Exact x/255 for x up to 255*255, without a divider.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

/* src/pab_in_if.sv */
// Input channel: one source pixel and one destination pixel per word.
interface pab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;
  logic [31:0] target_pixel;

  modport source (output valid, output source_pixel, output target_pixel, input ready);
  modport sink   (input valid, input source_pixel, input target_pixel, output ready);
endinterface

/* src/pab_out_if.sv */
// Result channel: one blended pixel and its write flag per word.
interface pab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] blended_pixel;
  logic        write_enable;

  modport source (output valid, output blended_pixel, output write_enable, input ready);
  modport sink   (input valid, input blended_pixel, input write_enable, output ready);
endinterface

/* src/pab_alpha.sv */
// First two pipeline stages: format decode, channel swap and effective alpha.
module pab_alpha
  import pab_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] src_pix,
  input  logic [31:0] dst_pix,
  input  logic [7:0]  global_alpha,
  input  fmt_t        source_format,
  input  fmt_t        target_format,
  output logic [31:0] s_out,
  output logic [31:0] d_out,
  output logic [7:0]  alpha_out,
  output blend_ctl_t  ctl_out
);

  // Stage one registers.
  logic [31:0] s1_src_r, s1_src_nxt;
  logic [31:0] s1_dst_r;
  logic [15:0] s1_prod_r, s1_prod_nxt;
  logic [7:0]  s1_ga_r;
  logic        s1_amode_r, s1_amode_nxt;
  logic        s1_skip_r, s1_skip_nxt;
  logic        s1_trunc_r, s1_trunc_nxt;
  b3_sel_t     s1_b3_r, s1_b3_nxt;

  // Stage two registers.
  logic [31:0] s2_src_r;
  logic [31:0] s2_dst_r;
  logic [7:0]  s2_alpha_r, s2_alpha_nxt;
  blend_ctl_t  s2_ctl_r, s2_ctl_nxt;

  logic        s_rev;
  logic        t_rev;
  logic        src_rgba;
  logic        dst_rgba;

  // Decode the formats and bring the source into the destination channel order.
  always_comb begin
    s_rev    = (source_format == FMT_BGR);
    t_rev    = (target_format == FMT_BGR);
    src_rgba = (source_format == FMT_RGBA);
    dst_rgba = (target_format == FMT_RGBA);
    if (s_rev != t_rev) begin
      s1_src_nxt = {src_pix[31:24], src_pix[7:0], src_pix[15:8], src_pix[23:16]};
    end else begin
      s1_src_nxt = src_pix;
    end
    s1_skip_nxt  = (global_alpha == 8'd0) || (source_format == FMT_RSVD) ||
                   (target_format == FMT_RSVD);
    s1_amode_nxt = src_rgba && !dst_rgba;
    s1_trunc_nxt = (src_rgba && !dst_rgba) || (!src_rgba && dst_rgba);
    s1_prod_nxt  = global_alpha * src_pix[31:24];
    if (!dst_rgba) begin
      s1_b3_nxt = B3_TARGET;
    end else if (src_rgba) begin
      s1_b3_nxt = B3_BLEND;
    end else begin
      s1_b3_nxt = B3_OPAQUE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_src_r   <= s1_src_nxt;
      s1_dst_r   <= dst_pix;
      s1_prod_r  <= s1_prod_nxt;
      s1_ga_r    <= global_alpha;
      s1_amode_r <= s1_amode_nxt;
      s1_skip_r  <= s1_skip_nxt;
      s1_trunc_r <= s1_trunc_nxt;
      s1_b3_r    <= s1_b3_nxt;
    end
  end

  // RGBA into RGB/BGR scales the source alpha by the global alpha; zero then skips.
  always_comb begin
    if (s1_amode_r) begin
      s2_alpha_nxt = div255(s1_prod_r);
    end else begin
      s2_alpha_nxt = s1_ga_r;
    end
    s2_ctl_nxt.skip   = s1_skip_r || (s1_amode_r && (s2_alpha_nxt == 8'd0));
    s2_ctl_nxt.copy   = (s2_alpha_nxt == ALPHA_FULL);
    s2_ctl_nxt.trunc  = s1_trunc_r;
    s2_ctl_nxt.b3_sel = s1_b3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_src_r   <= s1_src_r;
      s2_dst_r   <= s1_dst_r;
      s2_alpha_r <= s2_alpha_nxt;
      s2_ctl_r   <= s2_ctl_nxt;
    end
  end

  assign s_out     = s2_src_r;
  assign d_out     = s2_dst_r;
  assign alpha_out = s2_alpha_r;
  assign ctl_out   = s2_ctl_r;

endmodule

/* src/pab_lane.sv */
// One byte lane: registered difference product, then the scaled step added back.
module pab_lane
  import pab_pkg::*;
(
  input  logic       clk,
  input  logic       adv,
  input  logic [7:0] s,
  input  logic [7:0] d,
  input  logic [7:0] alpha,
  input  logic       trunc,
  input  logic       copy,
  output logic [7:0] value
);

  logic [15:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [7:0]  s_r;
  logic [7:0]  d_r;
  logic        trunc_r;
  logic        copy_r;
  logic [7:0]  absd;
  logic [16:0] up;
  logic [7:0]  q;

  // Magnitude of (s - d) * alpha, with its sign kept apart.
  always_comb begin
    neg_nxt = (s < d);
    absd    = neg_nxt ? (d - s) : (s - d);
    mag_nxt = absd * alpha;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      s_r     <= s;
      d_r     <= d;
      trunc_r <= trunc;
      copy_r  <= copy;
    end
  end

  // Truncating divide by 255, or a floor shift by 8 that rounds negatives down.
  always_comb begin
    up = {1'b0, mag_r} + 17'd255;
    if (trunc_r) begin
      q = div255(mag_r);
    end else if (neg_r) begin
      q = up[15:8];
    end else begin
      q = mag_r[15:8];
    end
    if (copy_r) begin
      value = s_r;
    end else if (neg_r) begin
      value = d_r - q;
    end else begin
      value = d_r + q;
    end
  end

endmodule

/* src/pixel_alpha_blend_core.sv */
// Top level of the pixel alpha blender: registers, pipeline control and result stage.
//
//  Port group  Direction  Carries
//  in_word     sink       source_pixel, target_pixel
//  out_word    source     blended_pixel, write_enable
//  cfg_*       sink       global_alpha, source_format, target_format
//
// One word is taken every clock while out_word is not stalled.
// The pipeline has four register stages: alpha scaling, its divide by 255,
// the per-lane product and the output register.
// Reset is synchronous on rst_n and clears valid bits and the configuration registers.
// A stall on out_word freezes the whole pipeline; in_word.ready follows it.
module pixel_alpha_blend_core
  import pab_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pab_in_if.sink      in_word,
  pab_out_if.source   out_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  global_alpha_r;
  fmt_t        source_format_r;
  fmt_t        target_format_r;

  logic        adv;
  logic        in_fire;
  logic        v1_r, v2_r, v3_r, vo_r;

  logic [31:0] s2;
  logic [31:0] d2;
  logic [7:0]  alpha2;
  blend_ctl_t  ctl2;

  blend_ctl_t  ctl3_r;
  logic [31:0] d3_r;
  logic [7:0]  lane_val [LANES];

  logic [31:0] pix_nxt;
  logic [31:0] pix_r;
  logic        we_nxt;
  logic        we_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_alpha_r  <= ALPHA_RESET;
      source_format_r <= FMT_RGB;
      target_format_r <= FMT_RGB;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GLOBAL_ALPHA:  global_alpha_r  <= cfg_data;
        CFG_SOURCE_FORMAT: source_format_r <= fmt_t'(cfg_data[1:0]);
        CFG_TARGET_FORMAT: target_format_r <= fmt_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register is free or being taken.
  assign adv           = !vo_r || out_word.ready;
  assign in_word.ready = adv;
  assign in_fire       = in_word.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  pab_alpha u_alpha (
    .clk           (clk),
    .adv           (adv),
    .src_pix       (in_word.source_pixel),
    .dst_pix       (in_word.target_pixel),
    .global_alpha  (global_alpha_r),
    .source_format (source_format_r),
    .target_format (target_format_r),
    .s_out         (s2),
    .d_out         (d2),
    .alpha_out     (alpha2),
    .ctl_out       (ctl2)
  );

  // Control and whole destination pixel alongside the lane stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl3_r <= ctl2;
      d3_r   <= d2;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    pab_lane u_lane (
      .clk   (clk),
      .adv   (adv),
      .s     (s2[8*k +: 8]),
      .d     (d2[8*k +: 8]),
      .alpha (alpha2),
      .trunc (ctl2.trunc),
      .copy  (ctl2.copy),
      .value (lane_val[k])
    );
  end

  // Assemble the result word; a skipped pixel repeats the destination.
  always_comb begin
    pix_nxt = {8'd0, lane_val[2], lane_val[1], lane_val[0]};
    case (ctl3_r.b3_sel)
      B3_TARGET: pix_nxt[31:24] = d3_r[31:24];
      B3_OPAQUE: pix_nxt[31:24] = ALPHA_FULL;
      B3_BLEND:  pix_nxt[31:24] = lane_val[3];
      default:   pix_nxt[31:24] = d3_r[31:24];
    endcase
    we_nxt = !ctl3_r.skip;
    if (ctl3_r.skip) begin
      pix_nxt = d3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r <= pix_nxt;
      we_r  <= we_nxt;
    end
  end

  assign out_word.valid         = vo_r;
  assign out_word.blended_pixel = pix_r;
  assign out_word.write_enable  = we_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the pixel alpha blend core with a blend predictor.
module tb
  import pab_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One expected result word.
  typedef struct packed {
    logic [31:0] pixel;
    logic        written;
  } blend_result_t;

  // Scoreboard: keeps a copy of the registers, predicts each blend and checks results.
  class blend_scoreboard;
    logic [7:0]    alpha;
    fmt_t          src_fmt;
    fmt_t          dst_fmt;
    blend_result_t pending_q[$];
    int            errors;

    function new();
      alpha   = ALPHA_RESET;
      src_fmt = FMT_RGB;
      dst_fmt = FMT_RGB;
      errors  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        CFG_GLOBAL_ALPHA:  alpha   = val;
        CFG_SOURCE_FORMAT: src_fmt = fmt_t'(val[1:0]);
        CFG_TARGET_FORMAT: dst_fmt = fmt_t'(val[1:0]);
        default: ;
      endcase
    endfunction

    // d + (s-d)*a/255, the quotient rounded towards zero.
    function logic [7:0] mix_trunc(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int prod;
      prod = (int'(s) - int'(d)) * int'(a);
      return 8'(int'(d) + prod / 255);
    endfunction

    // d + floor((s-d)*a/256); the arithmetic shift rounds towards minus infinity.
    function logic [7:0] mix_floor(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int prod;
      prod = (int'(s) - int'(d)) * int'(a);
      return 8'(int'(d) + (prod >>> 8));
    endfunction

    function blend_result_t blend_pixel(logic [31:0] src, logic [31:0] dst);
      blend_result_t r;
      logic [31:0]   s;
      logic [7:0]    a;
      r.pixel   = dst;
      r.written = 1'b0;
      if (alpha != 8'd0 && src_fmt != FMT_RSVD && dst_fmt != FMT_RSVD) begin
        // Red and blue trade places when only one side is in BGR order.
        if ((src_fmt == FMT_BGR) != (dst_fmt == FMT_BGR))
          s = {src[31:24], src[7:0], src[15:8], src[23:16]};
        else
          s = src;
        if (dst_fmt != FMT_RGBA) begin
          if (src_fmt == FMT_RGBA) begin
            // Per-pixel alpha, weighted by the global alpha; zero skips the pixel.
            a = src[31:24];
            if (a != 8'd0 && alpha != ALPHA_FULL)
              a = 8'((int'(alpha) * int'(a)) / 255);
            if (a != 8'd0) begin
              r.written = 1'b1;
              for (int k = 0; k < 3; k++)
                r.pixel[8*k +: 8] = (a == ALPHA_FULL) ? s[8*k +: 8]
                                    : mix_trunc(s[8*k +: 8], dst[8*k +: 8], a);
            end
          end else begin
            r.written = 1'b1;
            for (int k = 0; k < 3; k++)
              r.pixel[8*k +: 8] = (alpha == ALPHA_FULL) ? s[8*k +: 8]
                                  : mix_floor(s[8*k +: 8], dst[8*k +: 8], alpha);
          end
        end else if (src_fmt == FMT_RGBA) begin
          // Same-format blend: all four lanes, the source alpha does not weight.
          r.written = 1'b1;
          for (int k = 0; k < 4; k++)
            r.pixel[8*k +: 8] = (alpha == ALPHA_FULL) ? s[8*k +: 8]
                                : mix_floor(s[8*k +: 8], dst[8*k +: 8], alpha);
        end else begin
          // Three-byte source into RGBA: the alpha byte becomes opaque.
          r.written = 1'b1;
          r.pixel[31:24] = 8'hFF;
          for (int k = 0; k < 3; k++)
            r.pixel[8*k +: 8] = (alpha == ALPHA_FULL) ? s[8*k +: 8]
                                : mix_trunc(s[8*k +: 8], dst[8*k +: 8], alpha);
        end
      end
      return r;
    endfunction

    function void note_input(logic [31:0] src, logic [31:0] dst);
      pending_q.push_back(blend_pixel(src, dst));
    endfunction

    function void check_result(logic [31:0] pixel, logic written);
      blend_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: pixel %h we %b", pixel, written);
      end else begin
        want = pending_q.pop_front();
        if (want.pixel !== pixel || want.written !== written) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected pixel %h we %b, got pixel %h we %b",
                     want.pixel, want.written, pixel, written);
        end
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  pab_in_if  in_ch();
  pab_out_if out_ch();

  blend_scoreboard chk;

  bit sender_gaps;
  bit quiet_tail;
  bit long_hold_req;

  pixel_alpha_blend_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_ch),
    .out_word  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Accepted input words go to the predictor, accepted results to the checker.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      chk.note_input(in_ch.source_pixel, in_ch.target_pixel);
    if (rst_n && out_ch.valid && out_ch.ready)
      chk.check_result(out_ch.blended_pixel, out_ch.write_enable);
  end

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one word and wait until it is taken; valid stays high for the next word.
  task automatic send_word(input logic [31:0] src, input logic [31:0] dst);
    int gap;
    @(negedge clk);
    if (sender_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.source_pixel <= src;
    in_ch.target_pixel <= dst;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    chk.set_reg(idx, val);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic [7:0] a, input fmt_t sf, input fmt_t tf);
    drain();
    write_reg(CFG_GLOBAL_ALPHA, a);
    write_reg(CFG_SOURCE_FORMAT, 8'(sf));
    write_reg(CFG_TARGET_FORMAT, 8'(tf));
  endtask

  // Random word whose lanes now and then sit at 00 or FF.
  function automatic logic [31:0] edgy_word();
    logic [31:0] w;
    w = $urandom;
    for (int k = 0; k < 4; k++)
      if ($urandom_range(0, 7) == 0)
        w[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return w;
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      3, 4:    return 8'd255;
      5:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic fmt_t pick_format();
    if ($urandom_range(0, 15) == 0)
      return FMT_RSVD;
    return fmt_t'($urandom_range(0, 2));
  endfunction

  initial begin
    logic [31:0] src;
    chk = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_GLOBAL_ALPHA;
    cfg_data           = 8'd0;
    in_ch.valid        = 1'b0;
    in_ch.source_pixel = 32'd0;
    in_ch.target_pixel = 32'd0;
    sender_gaps        = 1'b1;
    quiet_tail         = 1'b0;
    long_hold_req      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: plain RGB copy.
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    // Zero global alpha writes nothing.
    set_mode(8'd0, FMT_RGB, FMT_RGB);
    send_word(32'h1234_5678, 32'h9ABC_DEF0);
    // RGBA source into RGB: zero alpha skips, full alpha copies, otherwise truncating blend.
    set_mode(8'd255, FMT_RGBA, FMT_RGB);
    send_word(32'h00FF_FFFF, 32'hA5A5_A5A5);
    send_word(32'hFF12_3456, 32'hA5A5_A5A5);
    send_word(32'h8010_80F0, 32'h00F0_2010);
    // Per-pixel alpha scaled by the global alpha, down to zero.
    set_mode(8'd100, FMT_RGBA, FMT_RGB);
    send_word(32'hC8FF_00FF, 32'h3300_FF00);
    send_word(32'h01FF_FFFF, 32'h1100_0000);
    // Same-format floor blend, source above and below destination.
    set_mode(8'd128, FMT_RGB, FMT_RGB);
    send_word(32'h00FF_00FF, 32'h7700_FF00);
    send_word(32'h0001_FE03, 32'h0002_FD04);
    // Three-byte source into RGBA: alpha byte forced opaque.
    set_mode(8'd255, FMT_RGB, FMT_RGBA);
    send_word(32'h0011_2233, 32'h4455_6677);
    set_mode(8'd77, FMT_RGB, FMT_RGBA);
    send_word(32'h00FF_00FF, 32'h0000_FF00);
    // RGBA to RGBA: full copy, then the weakest floor blend.
    set_mode(8'd255, FMT_RGBA, FMT_RGBA);
    send_word(32'h1020_3040, 32'hFFEE_DDCC);
    set_mode(8'd1, FMT_RGBA, FMT_RGBA);
    send_word(32'h00FF_00FF, 32'hFF00_FF00);
    // Channel order changes.
    set_mode(8'd255, FMT_BGR, FMT_RGB);
    send_word(32'hAA11_2233, 32'h5566_7788);
    set_mode(8'd255, FMT_RGB, FMT_BGR);
    send_word(32'hAA11_2233, 32'h5566_7788);
    set_mode(8'd200, FMT_BGR, FMT_BGR);
    send_word(32'h00FF_8001, 32'h0000_80FF);
    set_mode(8'd90, FMT_RGBA, FMT_BGR);
    send_word(32'h8001_0203, 32'hFFF0_E0D0);
    // Reserved format codes write nothing.
    set_mode(8'd255, FMT_RSVD, FMT_RGB);
    send_word(32'h1111_1111, 32'h2222_2222);
    set_mode(8'd255, FMT_RGB, FMT_RSVD);
    send_word(32'h3333_3333, 32'h4444_4444);

    // Random blocks, each under its own settings; the last ones without idling.
    for (int blk = 0; blk < 46; blk++) begin
      set_mode(pick_alpha(), pick_format(), pick_format());
      quiet_tail  = (blk >= 40);
      sender_gaps = (blk != 5);
      for (int i = 0; i < 25; i++) begin
        // One long receiver hold-off while the sender keeps offering words.
        if (blk == 5 && i == 3)
          long_hold_req = 1'b1;
        src = edgy_word();
        if ($urandom_range(0, 3) == 0)
          src[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_word(src, edgy_word());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
src/pab_pkg.sv
src/pab_in_if.sv
src/pab_out_if.sv
src/pab_alpha.sv
src/pab_lane.sv
src/pixel_alpha_blend_core.sv
tb/tb.sv
